// ===== rtl/vmb_pkg.sv =====
// shared types and constants for the viewport map with bounding box
`timescale 1ns / 1ps
`default_nettype none

package vmb_pkg;

    localparam int DATA_W = 32;
    localparam int VIEW_W = 13;
    localparam int BOX_W  = 20;
    localparam int CFG_W  = 2;

    typedef enum logic [CFG_W-1:0] {
        CFG_VIEW_LEFT   = 2'd0,
        CFG_VIEW_TOP    = 2'd1,
        CFG_VIEW_RIGHT  = 2'd2,
        CFG_VIEW_BOTTOM = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [BOX_W-1:0]  min_x;
        logic signed [BOX_W-1:0]  max_x;
        logic signed [BOX_W-1:0]  min_y;
        logic signed [BOX_W-1:0]  max_y;
        logic signed [DATA_W-1:0] min_z;
        logic signed [DATA_W-1:0] max_z;
    } t_box;

endpackage

`default_nettype wire

// ===== rtl/vmb_recip.sv =====
// serial restoring reciprocal 2^32 / w, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module vmb_recip (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]  i_w,
    output logic                                    o_done,
    output logic signed [vmb_pkg::DATA_W-1:0]       o_rw
);

    localparam int DW     = vmb_pkg::DATA_W;
    localparam int QBITS  = DW + 1;
    localparam int CNT_W  = $clog2(QBITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QBITS - 1);
    localparam logic [QBITS-1:0] POS_MAX   = QBITS'({1'b0, {(DW-1){1'b1}}});
    localparam logic [QBITS-1:0] NEG_MAG   = QBITS'(1) << (DW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [DW-1:0]           r_div;
    logic [QBITS-1:0]        r_rem;
    logic [QBITS-1:0]        r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_neg;
    logic                    r_zero;
    logic                    r_done;
    logic signed [DW-1:0]    r_rw;

    logic [QBITS-1:0]        trial;
    logic                    fits;
    logic signed [DW-1:0]    rw_final;

    // dividend is a single one above 32 zeros
    assign trial = {r_rem[DW-1:0], (r_cnt == '0)};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        if (r_zero) begin
            rw_final = '0;
        end else if (r_neg) begin
            if (r_quo > NEG_MAG) begin
                rw_final = $signed(NEG_MAG[DW-1:0]);
            end else begin
                rw_final = $signed(DW'(-r_quo[DW-1:0]));
            end
        end else begin
            if (r_quo > POS_MAX) begin
                rw_final = $signed(POS_MAX[DW-1:0]);
            end else begin
                rw_final = $signed(r_quo[DW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_div   <= i_w[DW-1] ? DW'(-i_w) : i_w;
                        r_neg   <= i_w[DW-1];
                        r_zero  <= (i_w == '0);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
                    r_quo <= {r_quo[QBITS-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_rw    <= rw_final;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rw   = r_rw;

endmodule

`default_nettype wire

// ===== rtl/vmb_mul.sv =====
// shared registered 32x32 signed multiplier
`timescale 1ns / 1ps
`default_nettype none

module vmb_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]    i_a,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]    i_b,
    output logic signed [2*vmb_pkg::DATA_W-1:0]       o_prod
);

    logic signed [2*vmb_pkg::DATA_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/vmb_box.sv =====
// running min/max of window position and depth, pixel box on the last item
`timescale 1ns / 1ps
`default_nettype none

module vmb_box #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_upd,
    input  wire logic                               i_last,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]  i_wx,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]  i_wy,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]  i_dz,
    output vmb_pkg::t_box                           o_box
);

    localparam int DW = vmb_pkg::DATA_W;
    localparam int BW = vmb_pkg::BOX_W;
    localparam logic signed [DW-1:0] PIX_MAX  = (DW'(1) <<< (BW - 1)) - DW'(1);
    localparam logic signed [DW-1:0] PIX_MIN  = -PIX_MAX - DW'(1);
    localparam logic signed [DW-1:0] RUN_INIT = {1'b0, {(DW-1){1'b1}}};

    function automatic logic signed [BW-1:0] to_pix(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] s;
        s = v >>> FRAC_BITS;
        if (s > PIX_MAX) begin
            return PIX_MAX[BW-1:0];
        end else if (s < PIX_MIN) begin
            return PIX_MIN[BW-1:0];
        end
        return s[BW-1:0];
    endfunction

    logic signed [DW-1:0] r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z;
    logic                 r_first;
    logic signed [DW-1:0] n_min_x, n_max_x, n_min_y, n_max_y, n_min_z, n_max_z;

    always_comb begin
        if (r_first) begin
            n_min_x = i_wx;
            n_max_x = i_wx;
            n_min_y = i_wy;
            n_max_y = i_wy;
            n_min_z = i_dz;
            n_max_z = i_dz;
        end else begin
            n_min_x = (i_wx < r_min_x) ? i_wx : r_min_x;
            n_max_x = (i_wx > r_max_x) ? i_wx : r_max_x;
            n_min_y = (i_wy < r_min_y) ? i_wy : r_min_y;
            n_max_y = (i_wy > r_max_y) ? i_wy : r_max_y;
            n_min_z = (i_dz < r_min_z) ? i_dz : r_min_z;
            n_max_z = (i_dz > r_max_z) ? i_dz : r_max_z;
        end
    end

    assign o_box.min_x = to_pix(n_min_x);
    assign o_box.max_x = to_pix(n_max_x);
    assign o_box.min_y = to_pix(n_min_y);
    assign o_box.max_y = to_pix(n_max_y);
    assign o_box.min_z = n_min_z;
    assign o_box.max_z = n_max_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_upd && i_last)) begin
            r_min_x <= RUN_INIT;
            r_max_x <= RUN_INIT;
            r_min_y <= RUN_INIT;
            r_max_y <= RUN_INIT;
            r_min_z <= '0;
            r_max_z <= '0;
            r_first <= 1'b1;
        end else if (i_upd) begin
            r_min_x <= n_min_x;
            r_max_x <= n_max_x;
            r_min_y <= n_min_y;
            r_max_y <= n_max_y;
            r_min_z <= n_min_z;
            r_max_z <= n_max_z;
            r_first <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/viewport_map_with_bounding_box.sv =====
// top level: perspective divide, viewport map and per-object bounding box
`timescale 1ns / 1ps
`default_nettype none

// One clip-space vertex goes in per item and one result comes out per item.
// An accepted item first waits for the serial reciprocal of w (one quotient
// bit per cycle over 33 bits, then a finishing state), then takes 12 steps of
// the single shared 32x32 multiplier and 64-bit adder (five per window axis,
// two for depth), and then loads the output register. The next item is
// accepted only after the state returns to idle. The input is stalled while an
// item is in work; a result waiting in the output register does not hold up
// the next item until that item is ready to leave. The user must write the
// viewport registers only while idle; the block does not enforce this.
module viewport_map_with_bounding_box #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_cfg_we,
    input  wire logic [vmb_pkg::CFG_W-1:0]                i_cfg_index,
    input  wire logic [vmb_pkg::VIEW_W-1:0]               i_cfg_data,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]        i_clip_x,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]        i_clip_y,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]        i_clip_z,
    input  wire logic signed [vmb_pkg::DATA_W-1:0]        i_clip_w,
    input  wire logic                                     i_final_vertex,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic signed [vmb_pkg::DATA_W-1:0]             o_window_x,
    output logic signed [vmb_pkg::DATA_W-1:0]             o_window_y,
    output logic signed [vmb_pkg::DATA_W-1:0]             o_depth,
    output logic signed [vmb_pkg::DATA_W-1:0]             o_recip_w,
    output logic                                          o_box_valid,
    output logic signed [vmb_pkg::BOX_W-1:0]              o_box_min_x,
    output logic signed [vmb_pkg::BOX_W-1:0]              o_box_max_x,
    output logic signed [vmb_pkg::BOX_W-1:0]              o_box_min_y,
    output logic signed [vmb_pkg::BOX_W-1:0]              o_box_max_y,
    output logic signed [vmb_pkg::DATA_W-1:0]             o_box_min_z,
    output logic signed [vmb_pkg::DATA_W-1:0]             o_box_max_z
);

    localparam int DW    = vmb_pkg::DATA_W;
    localparam int VW    = vmb_pkg::VIEW_W;
    localparam int PW    = 2 * DW;
    localparam int SHIFT = 17 - FRAC_BITS;
    localparam logic signed [PW-1:0] ROUND_BIAS = (PW'(1) <<< SHIFT) - PW'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECIP,
        S_MC,
        S_ML,
        S_MH,
        S_MA,
        S_WR,
        S_ZM,
        S_ZW,
        S_OUT
    } t_state;

    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[DW-1:0];
    endfunction

    // configuration
    logic [VW-1:0] r_view_left, r_view_top, r_view_right, r_view_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_left   <= '0;
            r_view_top    <= '0;
            r_view_right  <= '0;
            r_view_bottom <= '0;
        end else if (i_cfg_we) begin
            unique case (vmb_pkg::t_cfg_reg'(i_cfg_index))
                vmb_pkg::CFG_VIEW_LEFT:   r_view_left   <= i_cfg_data;
                vmb_pkg::CFG_VIEW_TOP:    r_view_top    <= i_cfg_data;
                vmb_pkg::CFG_VIEW_RIGHT:  r_view_right  <= i_cfg_data;
                vmb_pkg::CFG_VIEW_BOTTOM: r_view_bottom <= i_cfg_data;
            endcase
        end
    end

    t_state                 r_state;
    logic                   r_axis;
    logic signed [DW-1:0]   r_cx, r_cy, r_cz;
    logic                   r_last;
    logic signed [23:0]     r_nh;
    logic signed [PW-1:0]   r_acc;
    logic signed [DW-1:0]   r_wx, r_wy, r_dz;

    logic                   r_out_valid;
    logic signed [DW-1:0]   r_out_wx, r_out_wy, r_out_dz, r_out_rw;
    logic                   r_out_box_valid;
    vmb_pkg::t_box          r_out_box;

    logic                   in_take;
    logic                   out_take;
    logic                   out_load;
    logic                   recip_done;
    logic signed [DW-1:0]   rw;
    logic                   mul_en;
    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   add_a, add_b, sum, shifted;
    logic signed [13:0]     scale;
    logic signed [14:0]     ofs;
    logic signed [DW-1:0]   scale_ext;
    vmb_pkg::t_box          box;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_take = r_out_valid && !i_out_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // half-pixel scale and offset, y flipped
    always_comb begin
        if (r_axis) begin
            scale = $signed({1'b0, r_view_top}) - $signed({1'b0, r_view_bottom});
            ofs   = $signed({2'b00, r_view_top} + {2'b00, r_view_bottom} - 15'd1);
        end else begin
            scale = $signed({1'b0, r_view_right}) - $signed({1'b0, r_view_left});
            ofs   = $signed({2'b00, r_view_left} + {2'b00, r_view_right} - 15'd1);
        end
    end

    assign scale_ext = {{(DW-14){scale[13]}}, scale};

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        add_a  = r_acc;
        add_b  = '0;
        unique case (r_state)
            S_MC: begin
                mul_en = 1'b1;
                mul_a  = r_axis ? r_cy : r_cx;
                mul_b  = rw;
            end
            S_ML: begin
                mul_en = 1'b1;
                mul_a  = $signed({8'd0, prod[39:16]});
                mul_b  = scale_ext;
            end
            S_MH: begin
                mul_en = 1'b1;
                mul_a  = {{(DW-24){r_nh[23]}}, r_nh};
                mul_b  = scale_ext;
                add_a  = {{(PW-31){ofs[14]}}, ofs, 16'd0};
                add_b  = prod;
            end
            S_MA: begin
                add_b = {prod[PW-25:0], 24'd0};
            end
            S_WR: begin
                add_b = r_acc[PW-1] ? ROUND_BIAS : '0;
            end
            S_ZM: begin
                mul_en = 1'b1;
                mul_a  = r_cz;
                mul_b  = rw;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign sum     = add_a + add_b;
    assign shifted = sum >>> SHIFT;

    vmb_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_take),
        .i_w     (i_clip_w),
        .o_done  (recip_done),
        .o_rw    (rw)
    );

    vmb_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    vmb_box #(
        .FRAC_BITS (FRAC_BITS)
    ) u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (out_load),
        .i_last  (r_last),
        .i_wx    (r_wx),
        .i_wy    (r_wy),
        .i_dz    (r_dz),
        .o_box   (box)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_cx    <= i_clip_x;
                        r_cy    <= i_clip_y;
                        r_cz    <= i_clip_z;
                        r_last  <= i_final_vertex;
                        r_axis  <= 1'b0;
                        r_state <= S_RECIP;
                    end
                end
                S_RECIP: begin
                    if (recip_done) begin
                        r_state <= S_MC;
                    end
                end
                S_MC: r_state <= S_ML;
                S_ML: begin
                    r_nh    <= prod[63:40];
                    r_state <= S_MH;
                end
                S_MH: begin
                    r_acc   <= sum;
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_acc   <= sum;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (!r_axis) begin
                        r_wx    <= sat32(shifted);
                        r_axis  <= 1'b1;
                        r_state <= S_MC;
                    end else begin
                        r_wy    <= sat32(shifted);
                        r_state <= S_ZM;
                    end
                end
                S_ZM: r_state <= S_ZW;
                S_ZW: begin
                    r_dz    <= sat32(prod >>> 16);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_wx        <= r_wx;
                        r_out_wy        <= r_wy;
                        r_out_dz        <= r_dz;
                        r_out_rw        <= rw;
                        r_out_box_valid <= r_last;
                        r_out_box       <= r_last ? box : '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_window_x  = r_out_wx;
    assign o_window_y  = r_out_wy;
    assign o_depth     = r_out_dz;
    assign o_recip_w   = r_out_rw;
    assign o_box_valid = r_out_box_valid;
    assign o_box_min_x = r_out_box.min_x;
    assign o_box_max_x = r_out_box.max_x;
    assign o_box_min_y = r_out_box.min_y;
    assign o_box_max_y = r_out_box.max_y;
    assign o_box_min_z = r_out_box.min_z;
    assign o_box_max_z = r_out_box.max_z;

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared without the output step");

    a_recip_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        recip_done |-> (r_state == S_RECIP))
        else $error("reciprocal finished outside its wait state");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_box_valid) |->
            (r_out_box.min_x <= r_out_box.max_x) && (r_out_box.min_y <= r_out_box.max_y)
            && (r_out_box.min_z <= r_out_box.max_z))
        else $error("bounding box minimum above maximum");

    a_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_box_valid) |-> (r_out_box == '0))
        else $error("box fields nonzero on a non-final item");

endmodule

`default_nettype wire

// ===== bench/viewport_map_with_bounding_box_test.sv =====
// testbench for the viewport map with bounding box against an in-bench fixed-point model
`timescale 1ns / 1ps

module viewport_map_with_bounding_box_test;

    localparam int DATA_W    = vmb_pkg::DATA_W;
    localparam int VIEW_W    = vmb_pkg::VIEW_W;
    localparam int BOX_W     = vmb_pkg::BOX_W;
    localparam int CFG_W     = vmb_pkg::CFG_W;
    localparam int FRAC_BITS = 12;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] w;
        logic                     fin;
        int unsigned              gap;
    } t_vertex;

    typedef struct {
        logic signed [DATA_W-1:0] wx;
        logic signed [DATA_W-1:0] wy;
        logic signed [DATA_W-1:0] dz;
        logic signed [DATA_W-1:0] rw;
        logic                     box_on;
        vmb_pkg::t_box            box;
    } t_mapped;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_index = '0;
    logic [VIEW_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    t_vertex            in_item = '{default: '0};

    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_window_x;
    logic signed [DATA_W-1:0] o_window_y;
    logic signed [DATA_W-1:0] o_depth;
    logic signed [DATA_W-1:0] o_recip_w;
    logic                     o_box_valid;
    logic signed [BOX_W-1:0]  o_box_min_x;
    logic signed [BOX_W-1:0]  o_box_max_x;
    logic signed [BOX_W-1:0]  o_box_min_y;
    logic signed [BOX_W-1:0]  o_box_max_y;
    logic signed [DATA_W-1:0] o_box_min_z;
    logic signed [DATA_W-1:0] o_box_max_z;

    t_vertex     vertices_to_send[$];
    t_mapped     mapped_due[$];
    int unsigned sent_count = 0;
    int unsigned hold_count = 0;
    int unsigned stall_left = 0;
    int unsigned pause;
    bit          stall_on = 1'b1;
    int unsigned errors = 0;
    t_mapped     want;

    logic [VIEW_W-1:0] view_l = '0;
    logic [VIEW_W-1:0] view_t = '0;
    logic [VIEW_W-1:0] view_r = '0;
    logic [VIEW_W-1:0] view_b = '0;

    longint box_min_x = 64'sh7FFF_FFFF;
    longint box_max_x = 64'sh7FFF_FFFF;
    longint box_min_y = 64'sh7FFF_FFFF;
    longint box_max_y = 64'sh7FFF_FFFF;
    longint box_min_z = 0;
    longint box_max_z = 0;
    bit     box_empty = 1'b1;

    viewport_map_with_bounding_box #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_clip_x      (in_item.x),
        .i_clip_y      (in_item.y),
        .i_clip_z      (in_item.z),
        .i_clip_w      (in_item.w),
        .i_final_vertex(in_item.fin),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_window_x    (o_window_x),
        .o_window_y    (o_window_y),
        .o_depth       (o_depth),
        .o_recip_w     (o_recip_w),
        .o_box_valid   (o_box_valid),
        .o_box_min_x   (o_box_min_x),
        .o_box_max_x   (o_box_max_x),
        .o_box_min_y   (o_box_min_y),
        .o_box_max_y   (o_box_max_y),
        .o_box_min_z   (o_box_min_z),
        .o_box_max_z   (o_box_max_z)
    );

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint scale_axis(longint c, longint rw, longint span, longint ofs);
        longint n;
        longint t;
        n = (c * rw) >>> 16;
        t = n * span + ofs * 65536;
        return clamp(t / (longint'(1) <<< (17 - FRAC_BITS)), 32);
    endfunction

    task automatic map_vertex(t_vertex v);
        longint  cw;
        longint  rw;
        longint  wx;
        longint  wy;
        longint  dz;
        t_mapped r;
        cw = v.w;
        rw = 0;
        if (cw != 0) begin
            rw = clamp((longint'(1) <<< 32) / cw, 32);
        end
        wx = scale_axis(v.x, rw, longint'(view_r) - longint'(view_l),
                        longint'(view_l) + longint'(view_r) - 1);
        wy = scale_axis(v.y, rw, longint'(view_t) - longint'(view_b),
                        longint'(view_t) + longint'(view_b) - 1);
        dz = clamp((longint'(v.z) * rw) >>> 16, 32);
        if (box_empty) begin
            box_min_x = wx;
            box_max_x = wx;
            box_min_y = wy;
            box_max_y = wy;
            box_min_z = dz;
            box_max_z = dz;
            box_empty = 1'b0;
        end else begin
            if (wx < box_min_x) box_min_x = wx;
            if (wx > box_max_x) box_max_x = wx;
            if (wy < box_min_y) box_min_y = wy;
            if (wy > box_max_y) box_max_y = wy;
            if (dz < box_min_z) box_min_z = dz;
            if (dz > box_max_z) box_max_z = dz;
        end
        r.wx = wx[31:0];
        r.wy = wy[31:0];
        r.dz = dz[31:0];
        r.rw = rw[31:0];
        r.box_on = v.fin;
        r.box = '0;
        if (v.fin) begin
            r.box.min_x = BOX_W'(clamp(box_min_x >>> FRAC_BITS, BOX_W));
            r.box.max_x = BOX_W'(clamp(box_max_x >>> FRAC_BITS, BOX_W));
            r.box.min_y = BOX_W'(clamp(box_min_y >>> FRAC_BITS, BOX_W));
            r.box.max_y = BOX_W'(clamp(box_max_y >>> FRAC_BITS, BOX_W));
            r.box.min_z = box_min_z[31:0];
            r.box.max_z = box_max_z[31:0];
            box_min_x = 64'sh7FFF_FFFF;
            box_max_x = 64'sh7FFF_FFFF;
            box_min_y = 64'sh7FFF_FFFF;
            box_max_y = 64'sh7FFF_FFFF;
            box_min_z = 0;
            box_max_z = 0;
            box_empty = 1'b1;
        end
        mapped_due.push_back(r);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // quiet stretches of 32 items with no gaps between others with random gaps
    task automatic queue_vertex(t_vertex v);
        v.gap = ((sent_count / 32) % 3 == 0) ? 0 : $urandom_range(0, 4);
        sent_count++;
        vertices_to_send.push_back(v);
    endtask

    function automatic t_vertex vtx(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic signed [31:0] w,
                                    logic fin);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.w = w;
        v.fin = fin;
        v.gap = 0;
        return v;
    endfunction

    function automatic logic signed [31:0] near_range(longint span);
        return 32'(longint'($urandom_range(0, 32'(4 * span))) - 2 * span);
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex     v;
        int unsigned pick;
        longint      span;
        pick = $urandom_range(0, 99);
        v.x = $urandom;
        v.y = $urandom;
        v.z = $urandom;
        v.w = $urandom;
        if (pick < 60) begin
            span = $urandom_range(32'h0000_8000, 32'h0064_0000);
            v.w = (pick < 8) ? 32'(-span) : 32'(span);
            v.x = near_range(span);
            v.y = near_range(span);
            v.z = near_range(span);
        end else if (pick < 85 && pick >= 75) begin
            v.w = '0;
        end else if (pick >= 85) begin
            v.w = $urandom_range(1, 256);
            if (pick >= 93) v.w = -v.w;
        end
        v.fin = ($urandom_range(0, 5) == 0);
        v.gap = 0;
        return v;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (vertices_to_send.size() != 0 || in_valid || mapped_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_view(vmb_pkg::t_cfg_reg idx, logic [VIEW_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            vmb_pkg::CFG_VIEW_LEFT: begin
                view_l = val;
            end
            vmb_pkg::CFG_VIEW_TOP: begin
                view_t = val;
            end
            vmb_pkg::CFG_VIEW_RIGHT: begin
                view_r = val;
            end
            default: begin
                view_b = val;
            end
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_viewport(logic [VIEW_W-1:0] l, logic [VIEW_W-1:0] t,
                                logic [VIEW_W-1:0] r, logic [VIEW_W-1:0] b);
        wait_drained();
        write_view(vmb_pkg::CFG_VIEW_LEFT, l);
        write_view(vmb_pkg::CFG_VIEW_TOP, t);
        write_view(vmb_pkg::CFG_VIEW_RIGHT, r);
        write_view(vmb_pkg::CFG_VIEW_BOTTOM, b);
        @(negedge i_clk);
    endtask

    task automatic queue_random(int unsigned count);
        repeat (count) queue_vertex(random_vertex());
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            hold_count <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                map_vertex(in_item);
            end
            if (!in_valid || !o_in_stall) begin
                if (vertices_to_send.size() != 0 && hold_count >= vertices_to_send[0].gap) begin
                    in_item <= vertices_to_send.pop_front();
                    in_valid <= 1'b1;
                    hold_count <= 0;
                end else begin
                    in_valid <= 1'b0;
                    if (vertices_to_send.size() != 0) hold_count <= hold_count + 1;
                end
            end
        end
    end

    // the drawn wait is spent while the next result is waiting
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (mapped_due.size() == 0) begin
                $display("%0t unexpected item expected none actual window_x %h",
                         $time, o_window_x);
                errors++;
            end else begin
                want = mapped_due.pop_front();
                check_field("window_x", want.wx, o_window_x);
                check_field("window_y", want.wy, o_window_y);
                check_field("depth", want.dz, o_depth);
                check_field("recip_w", want.rw, o_recip_w);
                check_field("box_valid", 32'(want.box_on), 32'(o_box_valid));
                check_field("box_min_x", want.box.min_x, o_box_min_x);
                check_field("box_max_x", want.box.max_x, o_box_max_x);
                check_field("box_min_y", want.box.min_y, o_box_min_y);
                check_field("box_max_y", want.box.max_y, o_box_max_y);
                check_field("box_min_z", want.box.min_z, o_box_min_z);
                check_field("box_max_z", want.box.max_z, o_box_max_z);
            end
            pause = stall_on ? $urandom_range(0, 4) : 0;
            stall_left <= pause;
            out_stall <= (pause != 0);
        end else if (o_out_valid && stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (o_out_valid || stall_left == 0) begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset viewport of all zeros
        queue_random(10);

        set_viewport(13'd0, 13'd0, 13'd640, 13'd480);
        // single- and multi-vertex objects, zero w, extreme w and coordinates
        queue_vertex(vtx(32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 1'b1));
        queue_vertex(vtx(32'sh0003_0000, -32'sh0002_0000, 32'sh0001_8000, 32'sh0, 1'b1));
        queue_vertex(vtx(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1, 1'b0));
        queue_vertex(vtx(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh1, 1'b1));
        queue_vertex(vtx(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
        queue_vertex(vtx(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1));
        queue_vertex(vtx(32'sh0000_8000, -32'sh0000_8000, 32'sh0000_4000, -32'sh0001_0000, 1'b1));
        queue_vertex(vtx(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
                         1'b0));
        queue_vertex(vtx(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 32'sh0001_0000, 1'b0));
        queue_vertex(vtx(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0));
        queue_vertex(vtx(-32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b0));
        queue_vertex(vtx(32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0004_0000, 1'b1));
        queue_vertex(vtx(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, 32'sh0000_0100, 1'b1));
        queue_vertex(vtx(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, -32'sh0000_0100, 1'b1));
        queue_vertex(vtx(32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1));
        queue_random(70);

        set_viewport(13'd0, 13'd0, 13'd8191, 13'd8191);
        queue_random(80);

        // reversed on both axes, receiver never stalls
        stall_on = 1'b0;
        set_viewport(13'd8191, 13'd8191, 13'd0, 13'd0);
        queue_random(80);

        stall_on = 1'b1;
        set_viewport(13'd8191, 13'd0, 13'd0, 13'd8191);
        queue_random(80);

        repeat (3) begin
            set_viewport(VIEW_W'($urandom_range(0, 8191)), VIEW_W'($urandom_range(0, 8191)),
                         VIEW_W'($urandom_range(0, 8191)), VIEW_W'($urandom_range(0, 8191)));
            queue_random(60);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("viewport_map_with_bounding_box_test OK");
        end else begin
            $display("viewport_map_with_bounding_box_test NOT OK");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("viewport_map_with_bounding_box_test NOT OK");
        $finish;
    end

endmodule
